// ===== src/mvm_pkg.sv =====
package mvm_pkg;

	// Width of the configuration port address and the register decode
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int CFG_W = 13;
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic [CFG_W-1:0] COLUMNS_RESET = 13'd4096;

	// Item kinds
	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_MATRIX = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] element;
		logic [11:0]        vector_index;
	} item_t;

	typedef struct packed {
		logic signed [31:0] row_sum;
		logic [19:0]        row_index;
	} result_t;

endpackage

// ===== src/matrix_vector_multiply.sv =====
// Pipeline: a row result passes the store read stage, the product stage and the output register.
// Throughput: one transaction per cycle; the input stalls only while a finished row result
// is held by a stalled output and the row ending behind it needs the output register.
// Vector store: one memory, written by loads and read once per matrix element, read data registered.
// Reset clears the accumulator, column and row counters, valid flags and sets the width to 4096;
// the vector store holds no defined value until it is written.
module matrix_vector_multiply #(
	parameter int MAX_COLUMNS = 4096,
	parameter longint unsigned ROW_INDEX_LIMIT = 64'd1048576
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input transactions
	input  logic                       item_valid,
	output logic                       item_stall,
	input  mvm_pkg::item_t             item,
	// Result transactions
	output logic                       result_valid,
	input  logic                       result_stall,
	output mvm_pkg::result_t           result,
	// Configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mvm_pkg::ADDR_W-1:0] paddr,
	input  logic [mvm_pkg::DATA_W-1:0] pwdata,
	output logic [mvm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int WW = (CW > mvm_pkg::CFG_W) ? CW : mvm_pkg::CFG_W;
	localparam int IW = (AW > 12) ? AW : 12;
	localparam int RW = (ROW_INDEX_LIMIT > 64'd2) ? $clog2(ROW_INDEX_LIMIT) : 1;
	localparam int RX = (RW > 20) ? RW : 20;

	logic [mvm_pkg::CFG_W-1:0] columns_q;
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [31:0]               acc_q;

	logic                      valid_s1;
	logic                      last_s1;
	logic [31:0]               elem_s1;
	logic [31:0]               vec_s1;
	logic                      valid_s2;
	logic                      last_s2;
	logic [31:0]               prod_s2;

	logic                      result_valid_q;
	mvm_pkg::result_t          result_q;

	logic [31:0]               mem [MAX_COLUMNS];

	logic                      advance;
	logic                      accept;
	logic                      mat_accept;
	logic                      load_accept;
	logic                      load_in_range;
	logic [IW-1:0]             load_addr;
	logic [WW-1:0]             cfg_w;
	logic [WW-1:0]             eff_w;
	logic [WW-1:0]             col_next;
	logic                      row_end;
	logic [31:0]               acc_sum;
	logic [RX-1:0]             row_ext;
	logic                      cfg_write;

	// Configuration register access
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == mvm_pkg::REG_COLUMNS);

	always_comb begin
		prdata = '0;
		if (paddr[2] == mvm_pkg::REG_COLUMNS) begin
			prdata = mvm_pkg::DATA_W'(columns_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= mvm_pkg::COLUMNS_RESET;
		end else if (cfg_write) begin
			columns_q <= pwdata[mvm_pkg::CFG_W-1:0];
		end
	end

	// The pipeline holds only when a row result must go into an output register still stalled.
	assign advance = !(valid_s2 && last_s2 && result_valid_q && result_stall);
	assign item_stall = !advance;
	assign accept = item_valid && !item_stall;
	assign mat_accept = accept && (item.action == mvm_pkg::ACTION_MATRIX);
	assign load_accept = accept && (item.action == mvm_pkg::ACTION_LOAD);

	// Width in effect, clamped to one and to the store depth.
	always_comb begin
		cfg_w = WW'(columns_q);
		if (columns_q == '0) begin
			eff_w = WW'(1);
		end else if (cfg_w > WW'(MAX_COLUMNS)) begin
			eff_w = WW'(MAX_COLUMNS);
		end else begin
			eff_w = cfg_w;
		end
		col_next = WW'(col_q) + WW'(1);
		row_end = (col_next >= eff_w);
		load_in_range = (32'(item.vector_index) < 32'(MAX_COLUMNS));
		load_addr = IW'(item.vector_index);
	end

	// Column counter moves as each matrix element is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (mat_accept) begin
			col_q <= row_end ? '0 : col_next[CW-1:0];
		end
	end

	// Vector store: loads write, matrix elements read the current column.
	always_ff @(posedge clk) begin
		if (load_accept && load_in_range) begin
			mem[load_addr[AW-1:0]] <= item.element;
		end
		if (mat_accept) begin
			vec_s1 <= mem[col_q[AW-1:0]];
		end
	end

	// First stage: element and row end flag beside the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= mat_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_accept) begin
			elem_s1 <= item.element;
			last_s1 <= row_end;
		end
	end

	// Second stage: the low 32 bits of the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			prod_s2 <= elem_s1 * vec_s1;
			last_s2 <= last_s1;
		end
	end

	// Accumulation and row completion.
	assign acc_sum = acc_q + prod_s2;
	assign row_ext = RX'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			row_q <= '0;
		end else if (advance && valid_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				row_q <= (row_q == RW'(ROW_INDEX_LIMIT - 64'd1)) ? '0 : row_q + RW'(1);
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	// Output register: a held result is replaced only once it has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && valid_s2 && last_s2) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && last_s2) begin
			result_q.row_sum <= acc_sum;
			result_q.row_index <= row_ext[19:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int VEC_DEPTH = 4096;
	localparam int PIPE_SETTLE = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1150;
	localparam logic [mvm_pkg::ADDR_W-1:0] COLUMNS_ADDR =
		mvm_pkg::ADDR_W'(4 * int'(mvm_pkg::REG_COLUMNS));

	// Predicts row results from accepted transactions and checks the ones the block emits.
	class row_sum_scoreboard;
		logic [31:0]              vector_mem [VEC_DEPTH];
		bit                       loaded [VEC_DEPTH];
		logic [31:0]              acc = '0;
		int                       col_count = 0;
		logic [19:0]              row_num = '0;
		logic [mvm_pkg::CFG_W-1:0] columns_cfg = mvm_pkg::COLUMNS_RESET;
		mvm_pkg::result_t         pending_rows [$];
		int                       mismatches = 0;

		function void set_columns(logic [mvm_pkg::CFG_W-1:0] value);
			columns_cfg = value;
		endfunction

		// A width of zero behaves as one, anything above the store depth as the depth.
		function int row_width();
			if (columns_cfg == 0) return 1;
			if (int'(columns_cfg) > VEC_DEPTH) return VEC_DEPTH;
			return int'(columns_cfg);
		endfunction

		function void note_item(mvm_pkg::item_t it);
			logic [31:0]      vec_val;
			logic [31:0]      prod;
			mvm_pkg::result_t row;
			if (it.action == mvm_pkg::ACTION_LOAD) begin
				vector_mem[it.vector_index] = it.element;
				loaded[it.vector_index] = 1'b1;
				return;
			end
			vec_val = loaded[col_count] ? vector_mem[col_count] : 32'd0;
			prod = it.element * vec_val;
			acc = acc + prod;
			col_count++;
			if (col_count >= row_width()) begin
				row.row_sum = acc;
				row.row_index = row_num;
				pending_rows.push_back(row);
				acc = '0;
				col_count = 0;
				row_num = row_num + 20'd1;
			end
		endfunction

		function void check_result(mvm_pkg::result_t got);
			mvm_pkg::result_t want;
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row result: sum %0d index %0d",
						got.row_sum, got.row_index);
				return;
			end
			want = pending_rows.pop_front();
			if (got.row_sum !== want.row_sum || got.row_index !== want.row_index) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: expected sum %0d index %0d, got sum %0d index %0d",
						want.row_index, want.row_sum, want.row_index,
						got.row_sum, got.row_index);
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	mvm_pkg::item_t             item = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	mvm_pkg::result_t           result;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [mvm_pkg::ADDR_W-1:0] paddr = '0;
	logic [mvm_pkg::DATA_W-1:0] pwdata = '0;
	logic [mvm_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	row_sum_scoreboard sb = new;
	int                sent_items = 0;
	int                src_burst = 0;
	int                sink_burst = 0;
	int                idle_cycles = 0;

	matrix_vector_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// Mostly random gaps, with occasional stretches of back-to-back transactions.
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Element values lean towards the corners of the signed range.
	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Offers one input transaction and notes it once it is accepted.
	task automatic send_item(input logic act, input logic [31:0] value, input logic [11:0] idx);
		mvm_pkg::item_t it;
		int             gap;
		it.action = act;
		it.element = value;
		it.vector_index = idx;
		gap = draw_gap(src_burst);
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!(item_valid && !item_stall));
		sb.note_item(it);
		sent_items++;
	endtask

	// A matrix element; the vector entry for its column is loaded first if it never was.
	task automatic send_matrix(input logic [31:0] value);
		if (!sb.loaded[sb.col_count])
			send_item(mvm_pkg::ACTION_LOAD, rand_elem(), 12'(sb.col_count));
		send_item(mvm_pkg::ACTION_MATRIX, value, 12'($urandom_range(0, 4095)));
	endtask

	// Streams matrix elements until the current row has finished.
	task automatic send_row();
		do send_matrix(rand_elem()); while (sb.col_count != 0);
	endtask

	// Waits until every predicted row has come out and the pipeline has settled.
	task automatic drain_results();
		@(negedge clk) item_valid <= 1'b0;
		while (sb.pending_rows.size() != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [mvm_pkg::ADDR_W-1:0] addr,
		input logic [mvm_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_columns(input int value);
		drain_results();
		cfg_write(COLUMNS_ADDR, mvm_pkg::DATA_W'(value));
		sb.set_columns(mvm_pkg::CFG_W'(value));
	endtask

	// The result side stalls for a random gap before each transaction.
	initial begin
		int gap;
		forever begin
			gap = draw_gap(sink_burst);
			if (gap > 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
			sb.check_result(result);
		end
	end

	// Ends the run when neither channel has moved for too long.
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int width;
		int phase_len;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Corner values of the vector and the matrix at a width of four.
		set_columns(4);
		send_item(mvm_pkg::ACTION_LOAD, 32'h7fff_ffff, 12'd0);
		send_item(mvm_pkg::ACTION_LOAD, 32'h8000_0000, 12'd1);
		send_item(mvm_pkg::ACTION_LOAD, 32'hffff_ffff, 12'd2);
		send_item(mvm_pkg::ACTION_LOAD, 32'h0000_0000, 12'd3);
		send_item(mvm_pkg::ACTION_LOAD, 32'h5a5a_a5a5, 12'd4095);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h7fff_ffff, 12'd4095);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h8000_0000, 12'd0);
		// A load in the middle of a row changes the store only.
		send_item(mvm_pkg::ACTION_LOAD, 32'h0000_0001, 12'd3);
		send_item(mvm_pkg::ACTION_MATRIX, 32'hffff_ffff, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h0000_0000, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h8000_0000, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h8000_0000, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'h7fff_ffff, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'hffff_ffff, 12'd0);

		// A width of zero gives one-element rows.
		set_columns(0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'd5, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'hffff_fff9, 12'd0);

		// Lowering the width part-way through a row ends it on the next element.
		set_columns(3);
		send_item(mvm_pkg::ACTION_MATRIX, 32'd11, 12'd0);
		send_item(mvm_pkg::ACTION_MATRIX, 32'd13, 12'd0);
		set_columns(1);
		send_item(mvm_pkg::ACTION_MATRIX, 32'd17, 12'd0);

		// Random phases, mostly with narrow rows, each phase ending wherever it falls.
		while (sent_items < RANDOM_ITEMS + 20) begin
			case ($urandom_range(0, 19))
				0: width = 0;
				1: width = 1;
				2: width = $urandom_range(17, 64);
				default: width = $urandom_range(2, 16);
			endcase
			set_columns(width);
			phase_len = $urandom_range(20, 80);
			repeat (phase_len) begin
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 2) == 0)
						send_item(mvm_pkg::ACTION_LOAD, rand_elem(),
							12'($urandom_range(0, 4095)));
					else
						send_item(mvm_pkg::ACTION_LOAD, rand_elem(),
							12'($urandom_range(0, 63)));
				end else begin
					send_matrix(rand_elem());
				end
			end
		end

		// The largest legal width and one above the store depth both keep a row open,
		// and a narrow width then closes it.
		set_columns(VEC_DEPTH);
		repeat (4) send_matrix(rand_elem());
		set_columns(8191);
		repeat (4) send_matrix(rand_elem());
		set_columns(2);
		send_row();

		drain_results();
		repeat (8) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_rows.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
